// ===== design/itoa_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; imported by every module of the block.
package itoa_pkg;

    localparam int DIGIT_W = 4;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Control that travels with each item down the conversion pipeline.
    typedef struct packed {
        logic valid;
        logic negative;
    } itoa_ctl_t;

    // Double-dabble correction for one BCD digit before a shift.
    function automatic logic [DIGIT_W-1:0] dd_adjust(input logic [DIGIT_W-1:0] digit);
        logic [DIGIT_W-1:0] result;
        if (digit >= 4'd5)
        begin
            result = digit + 4'd3;
        end
        else
        begin
            result = digit;
        end
        return result;
    endfunction

endpackage

// ===== design/itoa_dd_stage.sv =====
// One register stage of the binary to BCD conversion: shifts STEP_BITS bits
// of the magnitude into the BCD digits. Depends on itoa_pkg.
module itoa_dd_stage
    import itoa_pkg::*;
#(
    parameter int BCD_W     = 40,
    parameter int REM_W     = 32,
    parameter int STEP_BITS = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  itoa_ctl_t        in_ctl,
    input  logic [BCD_W-1:0] in_bcd,
    input  logic [REM_W-1:0] in_rem,
    output itoa_ctl_t        out_ctl,
    output logic [BCD_W-1:0] out_bcd,
    output logic [REM_W-1:0] out_rem
);

    localparam int DIGITS = BCD_W / DIGIT_W;

    itoa_ctl_t        ctl_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;

    always_comb
    begin
        bcd_next = in_bcd;
        rem_next = in_rem;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                bcd_next[d*DIGIT_W +: DIGIT_W] = dd_adjust(bcd_next[d*DIGIT_W +: DIGIT_W]);
            end
            {bcd_next, rem_next} = {bcd_next, rem_next} << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bcd_reg <= bcd_next;
            rem_reg <= rem_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_bcd = bcd_reg;
    assign out_rem = rem_reg;

endmodule

// ===== design/itoa_emit.sv =====
// Character sequencer: takes a converted item, emits '-' if negative, then
// the digits from the most significant nonzero one down. Depends on itoa_pkg.
module itoa_emit
    import itoa_pkg::*;
#(
    parameter int DIGITS = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  itoa_ctl_t               in_ctl,
    input  logic [DIGITS*DIGIT_W-1:0] in_bcd,
    output logic                    take,
    output logic                    strobe,
    output logic [7:0]              character,
    output logic                    last
);

    localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic                      active_reg;
    logic                      sign_pend_reg;
    logic [CNT_W-1:0]          ptr_reg;
    logic [DIGITS*DIGIT_W-1:0] digits_reg;
    logic                      strobe_reg;
    logic [7:0]                character_reg;
    logic                      last_reg;
    logic [CNT_W-1:0]          msd;
    logic [DIGIT_W-1:0]        cur_digit;
    logic                      final_char;

    // Find the most significant nonzero digit; zero keeps the lowest digit.
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (in_bcd[d*DIGIT_W +: DIGIT_W] != '0)
            begin
                msd = CNT_W'(d);
            end
        end
    end

    assign cur_digit  = digits_reg[DIGIT_W*ptr_reg +: DIGIT_W];
    assign final_char = active_reg && !sign_pend_reg && (ptr_reg == '0);
    assign take       = !active_reg || final_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            sign_pend_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (take)
            begin
                active_reg    <= in_ctl.valid;
                sign_pend_reg <= in_ctl.valid && in_ctl.negative;
            end
            else if (sign_pend_reg)
            begin
                sign_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            digits_reg <= in_bcd;
            ptr_reg    <= msd;
        end
        else if (active_reg && !sign_pend_reg)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
        if (sign_pend_reg)
        begin
            character_reg <= ASCII_MINUS;
        end
        else
        begin
            character_reg <= ASCII_ZERO + {4'd0, cur_digit};
        end
        last_reg <= final_char;
    end

    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last      = last_reg;

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && (character_reg == ASCII_MINUS) |-> !last_reg)
        else $error("minus sign flagged as last character");

    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && sign_pend_reg |=> active_reg && !sign_pend_reg)
        else $error("sign not followed by a digit");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_ctl.valid |=> active_reg)
        else $error("transfer into sequencer did not start emission");

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// Top level: signed integer to decimal ASCII characters.
// Depends on itoa_pkg, itoa_dd_stage and itoa_emit.
//
// Usage:
//   Input: drive value and raise start; the transfer happens at a rising edge
//   where start is high and busy is low. busy is high while the sequencer is
//   partway through a number (any character but its final one); the whole
//   pipeline then holds, even where stages are empty.
//   Output: each character appears on character/last for one cycle with strobe
//   high. '-' comes first for a negative value, then the digits most
//   significant first with leading zeros dropped; zero gives a single '0'.
//   last marks the final character of each number.
//   Path: the transfer loads the magnitude stage, ceil(VALUE_BITS/4) BCD
//   stages follow (8 at 32 bits), then the sequencer load and its output
//   register, which drives strobe. The sequencer emits one character per
//   cycle, up to 11 per item at 32 bits (the digit count plus one for a sign),
//   and takes the next item with the final character; this sets throughput.
//   The receiver cannot stall: every strobe is a transfer.
//   Reset clears all valid bits and the sequencer state flags; no state lives between
//   items.
module signed_int_to_decimal_ascii
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         strobe,
    output logic [7:0]                   character,
    output logic                         last
);

    localparam int STEP_BITS  = 4;
    localparam int NUM_STAGES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int REM_W      = NUM_STAGES * STEP_BITS;
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = DIGITS * DIGIT_W;

    logic                  advance;
    logic                  take;
    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] magnitude;
    itoa_ctl_t             ctl0_reg;
    logic [REM_W-1:0]      rem0_reg;

    itoa_ctl_t        stg_ctl [NUM_STAGES+1];
    logic [BCD_W-1:0] stg_bcd [NUM_STAGES+1];
    logic [REM_W-1:0] stg_rem [NUM_STAGES+1];

    // Hold every stage while the sequencer is still emitting.
    assign advance = take;
    assign busy    = !advance;

    assign value_u   = value;
    assign magnitude = value_u[VALUE_BITS-1] ? (~value_u + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                                             : value_u;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (advance)
        begin
            ctl0_reg.valid    <= start;
            ctl0_reg.negative <= value_u[VALUE_BITS-1];
        end
    end

    // Pad with zeros above the magnitude; leading zeros shift through harmlessly.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem0_reg <= REM_W'(magnitude);
        end
    end

    assign stg_ctl[0] = ctl0_reg;
    assign stg_bcd[0] = '0;
    assign stg_rem[0] = rem0_reg;

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        itoa_dd_stage #(
            .BCD_W     (BCD_W),
            .REM_W     (REM_W),
            .STEP_BITS (STEP_BITS)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .in_ctl  (stg_ctl[g]),
            .in_bcd  (stg_bcd[g]),
            .in_rem  (stg_rem[g]),
            .out_ctl (stg_ctl[g+1]),
            .out_bcd (stg_bcd[g+1]),
            .out_rem (stg_rem[g+1])
        );
    end

    itoa_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (stg_ctl[NUM_STAGES]),
        .in_bcd    (stg_bcd[NUM_STAGES]),
        .take      (take),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ctl0_reg.valid)
        else $error("accepted transfer missing from first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> ctl0_reg == $past(ctl0_reg))
        else $error("first stage changed during stall");

    a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last raised without strobe");

endmodule
